@@ rtl/terminal_key_escape_encoder_macros.svh @@
// Assertion macros shared by the key escape encoder checker.
`ifndef TERMINAL_KEY_ESCAPE_ENCODER_MACROS_SVH
`define TERMINAL_KEY_ESCAPE_ENCODER_MACROS_SVH

// Checked property, masked while reset is high.
`define TKEE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("tkee: property failed");

// Checked property, evaluated through reset as well.
`define TKEE_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("tkee: property failed during or after reset");

`endif

@@ rtl/tkee_pkg.sv @@
// Types, constants and key tables for the key escape encoder.
package tkee_pkg;

   localparam int unsigned SEQ_MAX     = 8;
   localparam int unsigned KEY_COUNT   = 22;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ESC    = 8'd27;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;  // '['
   localparam logic [7:0] CHAR_SS3    = 8'h4F;  // 'O'
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;  // ';'
   localparam logic [7:0] CHAR_TILDE  = 8'h7E;  // '~'
   localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
   localparam logic [7:0] CHAR_ONE    = 8'h31;  // '1'

   typedef enum logic [1:0] {
      STATUS_BYTE    = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_NO_ROOM = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT, KEY_HOME, KEY_END,
      KEY_INSERT, KEY_DELETE, KEY_PGUP, KEY_PGDN,
      KEY_F1, KEY_F2, KEY_F3, KEY_F4, KEY_F5, KEY_F6,
      KEY_F7, KEY_F8, KEY_F9, KEY_F10, KEY_F11, KEY_F12
   } key_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic [3:0] modifiers;
      logic [7:0] buffer_room;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      status_type status;
      logic [3:0] sequence_length;
      logic       last;
   } rsp_type;

   // One classified key event, ready for the byte serializer.
   typedef struct packed {
      logic [SEQ_MAX-1:0][7:0] seq;
      logic [3:0]              len;
      status_type              status;
   } cmd_type;

   // Final letter of letter-terminated keys, zero for tilde keys.
   function automatic logic [7:0] final_letter(key_type key);
      logic [7:0] fin;
      case (key)
         KEY_UP:    fin = 8'h41;
         KEY_DOWN:  fin = 8'h42;
         KEY_RIGHT: fin = 8'h43;
         KEY_LEFT:  fin = 8'h44;
         KEY_HOME:  fin = 8'h48;
         KEY_END:   fin = 8'h46;
         KEY_F1:    fin = 8'h50;
         KEY_F2:    fin = 8'h51;
         KEY_F3:    fin = 8'h52;
         KEY_F4:    fin = 8'h53;
         default:   fin = 8'h00;
      endcase
      return fin;
   endfunction

   // Number written before the tilde.
   function automatic logic [4:0] tilde_number(key_type key);
      logic [4:0] num;
      case (key)
         KEY_INSERT: num = 5'd2;
         KEY_DELETE: num = 5'd3;
         KEY_PGUP:   num = 5'd5;
         KEY_PGDN:   num = 5'd6;
         KEY_F5:     num = 5'd15;
         KEY_F6:     num = 5'd17;
         KEY_F7:     num = 5'd18;
         KEY_F8:     num = 5'd19;
         KEY_F9:     num = 5'd20;
         KEY_F10:    num = 5'd21;
         KEY_F11:    num = 5'd23;
         KEY_F12:    num = 5'd24;
         default:    num = 5'd0;
      endcase
      return num;
   endfunction

endpackage

@@ rtl/terminal_key_escape_encoder.sv @@
// Top level of the terminal key escape sequence encoder.
//
// Request channel (req_): one key event per transfer: key code, modifier bits
// and the room left in the receiver's buffer. Response channel (rsp_): one
// byte of the escape sequence per transfer, with status, sequence length and
// a last flag on the final byte. A key that is unknown or whose sequence does
// not fit gives a single status transfer with last set.
// Both channels transfer when valid is high and stall is low.
// With the queue empty, the first byte of a request is registered in the
// queue and then in the output register before it is offered.
// Throughput: one response transfer per cycle while rsp_stall is low; an
// event gives 3 to 8 transfers (1 for a status result), paced by the byte
// serializer. A two-entry command queue lets new events be taken while bytes drain.
// req_stall is high only while the queue is full.
// Reset clears the queue and the output valid flag; nothing is in flight after.
// A stalled response holds its payload; the queue keeps filling until full.
module terminal_key_escape_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tkee_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tkee_pkg::rsp_type rsp_payload
);
   import tkee_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    head_valid;
   logic    pop;
   logic    full;
   logic    push;

   assign req_stall = full;
   assign push      = req_valid && !full;

   tkee_front u_front (
      .req (req_payload),
      .cmd (front_cmd)
   );

   tkee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tkee_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/tkee_front.sv @@
// Front end: classifies a key event and builds its escape sequence.
module tkee_front (
   input  tkee_pkg::req_type req,
   output tkee_pkg::cmd_type cmd
);
   import tkee_pkg::*;

   logic [4:0] mod_param;
   logic [4:0] num;
   logic [7:0] fin;
   logic [3:0] n;
   logic       unknown;
   key_type    key;
   logic [SEQ_MAX-1:0][7:0] seq;

   assign unknown   = (req.key_code >= 8'(KEY_COUNT));
   assign key       = key_type'(req.key_code[4:0]);
   assign fin       = final_letter(key);
   assign num       = tilde_number(key);
   assign mod_param = {1'b0, req.modifiers} + 5'd1;

   always_comb begin
      seq    = '0;
      seq[0] = CHAR_ESC;
      n      = 4'd1;
      if (fin != 8'h00) begin
         if (req.modifiers == 4'd0) begin
            seq[1] = (key >= KEY_F1) ? CHAR_SS3 : CHAR_LBRACK;
            seq[2] = fin;
            n      = 4'd3;
         end else begin
            seq[1] = CHAR_LBRACK;
            seq[2] = CHAR_ONE;
            seq[3] = CHAR_SEMI;
            n      = 4'd4;
            if (mod_param >= 5'd10) begin
               seq[n[2:0]] = CHAR_ONE;
               n           = n + 4'd1;
               seq[n[2:0]] = CHAR_ZERO + {3'b0, mod_param - 5'd10};
            end else begin
               seq[n[2:0]] = CHAR_ZERO + {3'b0, mod_param};
            end
            n           = n + 4'd1;
            seq[n[2:0]] = fin;
            n           = n + 4'd1;
         end
      end else begin
         seq[1] = CHAR_LBRACK;
         n      = 4'd2;
         // tilde numbers stay below 30
         if (num >= 5'd20) begin
            seq[n[2:0]] = CHAR_ZERO + 8'd2;
            n           = n + 4'd1;
            seq[n[2:0]] = CHAR_ZERO + {3'b0, num - 5'd20};
         end else if (num >= 5'd10) begin
            seq[n[2:0]] = CHAR_ONE;
            n           = n + 4'd1;
            seq[n[2:0]] = CHAR_ZERO + {3'b0, num - 5'd10};
         end else begin
            seq[n[2:0]] = CHAR_ZERO + {3'b0, num};
         end
         n = n + 4'd1;
         if (req.modifiers != 4'd0) begin
            seq[n[2:0]] = CHAR_SEMI;
            n           = n + 4'd1;
            if (mod_param >= 5'd10) begin
               seq[n[2:0]] = CHAR_ONE;
               n           = n + 4'd1;
               seq[n[2:0]] = CHAR_ZERO + {3'b0, mod_param - 5'd10};
            end else begin
               seq[n[2:0]] = CHAR_ZERO + {3'b0, mod_param};
            end
            n = n + 4'd1;
         end
         seq[n[2:0]] = CHAR_TILDE;
         n           = n + 4'd1;
      end
   end

   always_comb begin
      if (unknown) begin
         cmd = '{seq: '0, len: 4'd0, status: STATUS_UNKNOWN};
      end else if (req.buffer_room < {4'b0, n}) begin
         cmd = '{seq: '0, len: 4'd0, status: STATUS_NO_ROOM};
      end else begin
         cmd = '{seq: seq, len: n, status: STATUS_BYTE};
      end
   end

endmodule

@@ rtl/tkee_queue.sv @@
// Short command queue between the front end and the serializer.
module tkee_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tkee_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tkee_pkg::cmd_type head_cmd
);
   import tkee_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] q;
      q = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      return q;
   endfunction

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/tkee_back.sv @@
// Back end: serializes the head command, one result transfer per cycle unless stalled.
module tkee_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  tkee_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tkee_pkg::rsp_type rsp_payload
);
   import tkee_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic       load;
   logic       byte_last;

   assign load      = head_valid && (!valid_ff || !rsp_stall);
   assign byte_last = (head_cmd.status != STATUS_BYTE) ||
                      (({1'b0, idx_ff} + 4'd1) == head_cmd.len);
   assign pop       = load && byte_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      out_in   = out_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = byte_last ? 3'd0 : idx_ff + 3'd1;
         out_in   = '{data_byte:       head_cmd.seq[idx_ff],
                      status:          head_cmd.status,
                      sequence_length: head_cmd.len,
                      last:            byte_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ rtl/tkee_checker.sv @@
// Port-level checker for the key escape encoder and its bind.
`include "terminal_key_escape_encoder_macros.svh"

module tkee_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tkee_pkg::rsp_type rsp_payload
);
   import tkee_pkg::*;

   logic req_xfer;
   logic rsp_is_status;
   logic rsp_is_byte;
   logic status_clean;
   logic len_ok;

   assign req_xfer      = req_valid && !req_stall;
   assign rsp_is_status = rsp_valid && (rsp_payload.status != STATUS_BYTE);
   assign rsp_is_byte   = rsp_valid && (rsp_payload.status == STATUS_BYTE);
   assign status_clean  = rsp_payload.last && (rsp_payload.data_byte == 8'd0) &&
                          (rsp_payload.sequence_length == 4'd0);
   assign len_ok        = (rsp_payload.sequence_length >= 4'd3) &&
                          (rsp_payload.sequence_length <= 4'd8);

   // a status result carries no byte and closes its event
   `TKEE_ASSERT(a_status_only, rsp_is_status |-> status_clean)

   // byte transfers always report a real sequence length
   `TKEE_ASSERT(a_seq_len, rsp_is_byte |-> len_ok)

   // a request into an idle output is offered once it has passed the queue and the output register
   `TKEE_ASSERT(a_first_byte, req_xfer && !rsp_valid |-> ##2 rsp_valid)

   // output register holds while stalled
   `TKEE_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   `TKEE_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid && !req_stall)

endmodule

bind terminal_key_escape_encoder tkee_checker u_tkee_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the terminal key escape sequence encoder.
module testbench;
   import tkee_pkg::*;

   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned PRINT_LIMIT = 50;

   // Predicts the escape bytes of each accepted key event and checks them in order.
   class escape_scoreboard;
      rsp_type    pending_bytes[$];
      logic [7:0] byte_buf[$];
      int         fail_count;

      function logic [7:0] letter_of(key_type key);
         case (key)
            KEY_UP:    return "A";
            KEY_DOWN:  return "B";
            KEY_RIGHT: return "C";
            KEY_LEFT:  return "D";
            KEY_HOME:  return "H";
            KEY_END:   return "F";
            KEY_F1:    return "P";
            KEY_F2:    return "Q";
            KEY_F3:    return "R";
            KEY_F4:    return "S";
            default:   return 8'h00;
         endcase
      endfunction

      function int unsigned tilde_code_of(key_type key);
         case (key)
            KEY_INSERT: return 2;
            KEY_DELETE: return 3;
            KEY_PGUP:   return 5;
            KEY_PGDN:   return 6;
            KEY_F5:     return 15;
            KEY_F6:     return 17;
            KEY_F7:     return 18;
            KEY_F8:     return 19;
            KEY_F9:     return 20;
            KEY_F10:    return 21;
            KEY_F11:    return 23;
            KEY_F12:    return 24;
            default:    return 0;
         endcase
      endfunction

      function void add_decimal(int unsigned v);
         if (v >= 10) begin
            byte_buf.push_back(CHAR_ZERO + 8'(v / 10));
         end
         byte_buf.push_back(CHAR_ZERO + 8'(v % 10));
      endfunction

      function void note_request(req_type r);
         key_type     key;
         logic [7:0]  letter;
         int unsigned m;
         int unsigned len;
         rsp_type     item;
         byte_buf.delete();
         item = '0;
         item.last = 1'b1;
         if (r.key_code >= KEY_COUNT) begin
            item.status = STATUS_UNKNOWN;
            pending_bytes.push_back(item);
            return;
         end
         key = key_type'(r.key_code[4:0]);
         letter = letter_of(key);
         // modifier bits already carry their weights
         m = 1 + r.modifiers;
         byte_buf.push_back(CHAR_ESC);
         if (letter != 8'h00) begin
            if (r.modifiers == 4'd0) begin
               byte_buf.push_back((key >= KEY_F1) ? CHAR_SS3 : CHAR_LBRACK);
            end else begin
               byte_buf.push_back(CHAR_LBRACK);
               byte_buf.push_back(CHAR_ONE);
               byte_buf.push_back(CHAR_SEMI);
               add_decimal(m);
            end
            byte_buf.push_back(letter);
         end else begin
            byte_buf.push_back(CHAR_LBRACK);
            add_decimal(tilde_code_of(key));
            if (r.modifiers != 4'd0) begin
               byte_buf.push_back(CHAR_SEMI);
               add_decimal(m);
            end
            byte_buf.push_back(CHAR_TILDE);
         end
         len = byte_buf.size();
         if (r.buffer_room < len) begin
            item.status = STATUS_NO_ROOM;
            pending_bytes.push_back(item);
            return;
         end
         for (int unsigned i = 0; i < len; i++) begin
            item.data_byte = byte_buf[i];
            item.status = STATUS_BYTE;
            item.sequence_length = 4'(len);
            item.last = (i == len - 1);
            pending_bytes.push_back(item);
         end
      endfunction

      task report(string what);
         fail_count++;
         if (fail_count <= PRINT_LIMIT) begin
            $display("mismatch: %s", what);
         end
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_bytes.size() == 0) begin
            report($sformatf("result byte %02h with nothing pending", got.data_byte));
            return;
         end
         want = pending_bytes.pop_front();
         if (got.data_byte !== want.data_byte) begin
            report($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
         end
         if (got.status !== want.status) begin
            report($sformatf("status %0d, want %0d", got.status, want.status));
         end
         if (got.sequence_length !== want.sequence_length) begin
            report($sformatf("sequence_length %0d, want %0d",
                             got.sequence_length, want.sequence_length));
         end
         if (got.last !== want.last) begin
            report($sformatf("last %0b, want %0b", got.last, want.last));
         end
      endtask

      task check_leftovers();
         if (pending_bytes.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_bytes.size()));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   escape_scoreboard sb = new;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   terminal_key_escape_encoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Result checking and watchdog on transfers of either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_payload);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task send_event(req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task send_key(int unsigned key, int unsigned mods, int unsigned room);
      req_type r;
      r.key_code = 8'(key);
      r.modifiers = 4'(mods);
      r.buffer_room = 8'(room);
      send_event(r);
   endtask

   function automatic req_type random_key_event(bit known_only);
      req_type     r;
      int unsigned pick;
      if (!known_only && $urandom_range(99) < 8) begin
         r.key_code = 8'($urandom_range(255, KEY_COUNT));
      end else begin
         r.key_code = 8'($urandom_range(KEY_COUNT - 1, 0));
      end
      r.modifiers = ($urandom_range(99) < 30) ? 4'd0 : 4'($urandom);
      pick = $urandom_range(99);
      if (known_only || pick < 50) begin
         r.buffer_room = 8'($urandom_range(255, 8));
      end else if (pick < 80) begin
         // near the sequence lengths, to hit both sides of the room check
         r.buffer_room = 8'($urandom_range(9, 0));
      end else begin
         r.buffer_room = 8'($urandom);
      end
      return r;
   endfunction

   // Sender pauses until every pending result has been checked.
   task wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending_bytes.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every key class, field extremes, room edges, unknown keys
      send_key(KEY_UP, 0, 255);
      send_key(KEY_F12, 15, 255);
      send_key(KEY_F12, 15, 8);
      send_key(KEY_F12, 15, 7);
      send_key(KEY_F1, 0, 3);
      send_key(KEY_F4, 15, 255);
      send_key(KEY_F2, 1, 6);
      send_key(KEY_HOME, 0, 3);
      send_key(KEY_END, 8, 255);
      send_key(KEY_LEFT, 0, 2);
      send_key(KEY_INSERT, 0, 4);
      send_key(KEY_PGDN, 9, 255);
      send_key(KEY_F5, 0, 5);
      send_key(KEY_F9, 2, 255);
      send_key(KEY_DELETE, 4, 6);
      send_key(KEY_DOWN, 0, 0);
      send_key(KEY_COUNT, 0, 255);
      send_key(255, 15, 0);
      send_key(128, 5, 170);
      send_key(KEY_RIGHT, 6, 85);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         for (int n = 0; n < 110; n++) begin
            send_event(random_key_event(1'b0));
         end
         wait_drained();
      end

      // long receiver hold-off while the sender keeps offering events
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_left = 300;
      for (int n = 0; n < 20; n++) begin
         send_event(random_key_event(1'b1));
      end
      wait_drained();

      repeat (16) @(negedge clock);
      sb.check_leftovers();
      if (sb.fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
